// ===== rtl/lz4bd_pkg.sv =====
// Shared types and constants for the LZ4 block decoder.
// No dependencies; used by lz4_block_decoder_top and the testbench.
`timescale 1ns / 1ps

package lz4bd_pkg;

    // Decoder phase, one-hot
    typedef enum logic [7:0] {
        PH_TOKEN  = 8'b0000_0001,
        PH_LITEXT = 8'b0000_0010,
        PH_LIT    = 8'b0000_0100,
        PH_OFF0   = 8'b0000_1000,
        PH_OFF1   = 8'b0001_0000,
        PH_MEXT   = 8'b0010_0000,
        PH_COPY   = 8'b0100_0000,
        PH_DROP   = 8'b1000_0000
    } phase_t;

    // Block status codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_LITLEN_CUT = 4'd1,
        ST_LIT_OVF    = 4'd2,
        ST_LITS_CUT   = 4'd3,
        ST_OFFSET_CUT = 4'd4,
        ST_ZERO_OFF   = 4'd5,
        ST_MLEN_CUT   = 4'd6,
        ST_OFF_FAR    = 4'd7,
        ST_MATCH_OVF  = 4'd8,
        ST_PUSH_COPY  = 4'd9
    } status_t;

    // Input actions
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_COPY = 1'b1;

    // Field widths and limits
    localparam int LEN_W  = 32;
    localparam int CNT_W  = 31;
    localparam int DIST_W = 16;
    localparam logic [LEN_W-1:0] LEN_MAX      = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CAP_RESET    = 31'd65536;
    localparam logic [3:0]       NIBBLE_EXT   = 4'hF;
    localparam logic [7:0]       BYTE_EXT     = 8'd255;
    localparam logic [LEN_W-1:0] MATCH_MIN    = 32'd4;

    // Register map: word index
    localparam logic REG_OUT_CAPACITY = 1'b0;

    // One stage of the result pipeline
    typedef struct packed {
        logic             is_copy;
        logic             has_byte;
        logic             block_end;
        logic [3:0]       status;
        logic [CNT_W-1:0] length;
        logic [7:0]       lit_byte;
    } stage_t;

endpackage

// ===== rtl/lz4_block_decoder_top.sv =====
// LZ4 block decoder: token/length/offset parsing, history window and result pipeline.
// Depends on lz4bd_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): each item is either a push of one
//   compressed byte (action 0, in_byte, last marks the final byte of a block)
//   or a copy tick (action 1) that emits the next byte of a pending match.
//   Output channel (out_valid/out_ready): one result per emitted byte or per
//   block end, carrying out_byte, has_byte, block_end, status, out_length.
//   Pushes of token, offset and length-extension bytes give no result unless they end the block.
//   Throughput is one item per cycle while results are taken; the edge
//   that accepts an item loads the middle stage with the parse result and
//   the registered window read, and the result moves on from there into
//   the output register when the middle stage advances.
//   A stalled receiver holds the output register; the middle stage holds
//   behind it and in_ready drops only when both stages are full.
//   Reset returns the parser to expect a token, clears the length counters
//   and sets out_capacity to 65536. The history window is not cleared: every
//   match reads only bytes written earlier in the same block.
//   out_capacity sits at APB byte address 0 and should be written while idle.
module lz4_block_decoder_top #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  in_byte,
    input  logic        last,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        block_end,
    output logic [3:0]  status,
    output logic [30:0] out_length,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(WINDOW_BYTES);
    localparam int LEN_W  = lz4bd_pkg::LEN_W;
    localparam int CNT_W  = lz4bd_pkg::CNT_W;
    localparam int DIST_W = lz4bd_pkg::DIST_W;

    // Configuration register
    logic [CNT_W-1:0] cap_reg;

    // Parser state
    lz4bd_pkg::phase_t phase_reg, phase_next;
    logic [LEN_W-1:0]  lit_reg, lit_next;
    logic [LEN_W-1:0]  mat_reg, mat_next;
    logic [3:0]        nib_reg, nib_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [CNT_W-1:0]  prod_reg, prod_next;
    logic              endp_reg, endp_next;

    // Pipeline stages
    logic              s1_valid_reg;
    lz4bd_pkg::stage_t s1_reg;
    logic [ADDR_W-1:0] s1_waddr_reg;
    logic              s1_fwd_reg;
    logic [7:0]        s1_fwd_byte_reg;
    logic [7:0]        mem_q_reg;
    logic              s2_valid_reg;
    lz4bd_pkg::stage_t s2_reg;
    logic [7:0]        s2_byte_reg;

    // History window
    logic [7:0] window_mem [WINDOW_BYTES];

    // Handshake
    logic in_acc;
    logic s1_adv;
    assign s1_adv   = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // APB port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == lz4bd_pkg::REG_OUT_CAPACITY);
    always_comb
    begin
        if (paddr[2] == lz4bd_pkg::REG_OUT_CAPACITY)
            prdata = {1'b0, cap_reg};
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lz4bd_pkg::CAP_RESET;
        else if (cfg_wr)
            cap_reg <= pwdata[CNT_W-1:0];
    end

    // Length candidates: token nibble or saturated extension
    logic [LEN_W:0]    lit_sum, mat_sum;
    logic [LEN_W-1:0]  lit_sat, mat_sat, lit_cand, mat_cand;
    logic [DIST_W-1:0] dist_cand;
    logic [LEN_W+1:0]  lit_total, mat_total;
    logic              lit_over, mat_over, dist_far;
    logic [CNT_W-1:0]  prod_inc;
    logic [LEN_W-1:0]  lit_dec, mat_dec;

    assign lit_sum  = {1'b0, lit_reg} + {{(LEN_W-7){1'b0}}, in_byte};
    assign mat_sum  = {1'b0, mat_reg} + {{(LEN_W-7){1'b0}}, in_byte};
    assign lit_sat  = lit_sum[LEN_W] ? lz4bd_pkg::LEN_MAX : lit_sum[LEN_W-1:0];
    assign mat_sat  = mat_sum[LEN_W] ? lz4bd_pkg::LEN_MAX : mat_sum[LEN_W-1:0];
    assign lit_cand = (phase_reg == lz4bd_pkg::PH_LITEXT) ? lit_sat
                                                          : {28'd0, in_byte[7:4]};
    assign mat_cand = (phase_reg == lz4bd_pkg::PH_MEXT) ? mat_sat
                                                        : lz4bd_pkg::MATCH_MIN
                                                          + {28'd0, nib_reg};
    assign dist_cand = (phase_reg == lz4bd_pkg::PH_OFF1) ? {in_byte, dist_reg[7:0]}
                                                         : dist_reg;
    assign lit_total = {3'b0, prod_reg} + {2'b0, lit_cand};
    assign mat_total = {3'b0, prod_reg} + {2'b0, mat_cand};
    assign lit_over  = lit_total > {3'b0, cap_reg};
    assign mat_over  = mat_total > {3'b0, cap_reg};
    assign dist_far  = {{(CNT_W-DIST_W){1'b0}}, dist_cand} > prod_reg;
    assign prod_inc  = prod_reg + 1'b1;
    assign lit_dec   = lit_reg - 1'b1;
    assign mat_dec   = mat_reg - 1'b1;

    // Parse one item
    logic       res_valid, res_emit, fin;
    logic [3:0] fin_st;
    logic       fin_last;

    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        mat_next   = mat_reg;
        nib_next   = nib_reg;
        dist_next  = dist_reg;
        prod_next  = prod_reg;
        endp_next  = endp_reg;
        res_valid  = 1'b0;
        res_emit   = 1'b0;
        fin        = 1'b0;
        fin_st     = lz4bd_pkg::ST_OK;
        fin_last   = last;

        if (action == lz4bd_pkg::ACT_COPY) begin
            // copy tick: only meaningful while a match is pending
            if (phase_reg == lz4bd_pkg::PH_COPY) begin
                res_valid = 1'b1;
                res_emit  = 1'b1;
                prod_next = prod_inc;
                mat_next  = mat_dec;
                if (mat_dec == '0) begin
                    phase_next = lz4bd_pkg::PH_TOKEN;
                    if (endp_reg) begin
                        fin      = 1'b1;
                        fin_last = 1'b1;
                    end
                end
            end
        end else begin
            unique case (phase_reg)
                lz4bd_pkg::PH_TOKEN, lz4bd_pkg::PH_LITEXT:
                begin
                    lit_next = lit_cand;
                    if (phase_reg == lz4bd_pkg::PH_TOKEN)
                        nib_next = in_byte[3:0];
                    if ((phase_reg == lz4bd_pkg::PH_TOKEN
                         && in_byte[7:4] == lz4bd_pkg::NIBBLE_EXT)
                        || (phase_reg == lz4bd_pkg::PH_LITEXT
                            && in_byte == lz4bd_pkg::BYTE_EXT)) begin
                        // length continues in the next byte
                        if (last) begin
                            fin    = 1'b1;
                            fin_st = lz4bd_pkg::ST_LITLEN_CUT;
                        end else begin
                            phase_next = lz4bd_pkg::PH_LITEXT;
                        end
                    end else if (lit_over) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_LIT_OVF;
                    end else if (lit_cand == '0) begin
                        if (last)
                            fin = 1'b1;
                        else
                            phase_next = lz4bd_pkg::PH_OFF0;
                    end else if (last) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_LITS_CUT;
                    end else begin
                        phase_next = lz4bd_pkg::PH_LIT;
                    end
                end
                lz4bd_pkg::PH_LIT:
                begin
                    res_valid = 1'b1;
                    res_emit  = 1'b1;
                    prod_next = prod_inc;
                    lit_next  = lit_dec;
                    if (lit_dec == '0) begin
                        if (last)
                            fin = 1'b1;
                        else
                            phase_next = lz4bd_pkg::PH_OFF0;
                    end else if (last) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_LITS_CUT;
                    end
                end
                lz4bd_pkg::PH_OFF0:
                begin
                    dist_next = {8'd0, in_byte};
                    if (last) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_OFFSET_CUT;
                    end else begin
                        phase_next = lz4bd_pkg::PH_OFF1;
                    end
                end
                lz4bd_pkg::PH_OFF1, lz4bd_pkg::PH_MEXT:
                begin
                    dist_next = dist_cand;
                    mat_next  = mat_cand;
                    if (phase_reg == lz4bd_pkg::PH_OFF1 && dist_cand == '0) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_ZERO_OFF;
                    end else if ((phase_reg == lz4bd_pkg::PH_OFF1
                                  && nib_reg == lz4bd_pkg::NIBBLE_EXT)
                                 || (phase_reg == lz4bd_pkg::PH_MEXT
                                     && in_byte == lz4bd_pkg::BYTE_EXT)) begin
                        // match length continues in the next byte
                        if (last) begin
                            fin    = 1'b1;
                            fin_st = lz4bd_pkg::ST_MLEN_CUT;
                        end else begin
                            phase_next = lz4bd_pkg::PH_MEXT;
                        end
                    end else if (dist_far) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_OFF_FAR;
                    end else if (mat_over) begin
                        fin    = 1'b1;
                        fin_st = lz4bd_pkg::ST_MATCH_OVF;
                    end else begin
                        endp_next  = last;
                        phase_next = lz4bd_pkg::PH_COPY;
                    end
                end
                lz4bd_pkg::PH_COPY:
                begin
                    fin    = 1'b1;
                    fin_st = lz4bd_pkg::ST_PUSH_COPY;
                end
                lz4bd_pkg::PH_DROP:
                begin
                    if (last)
                        phase_next = lz4bd_pkg::PH_TOKEN;
                end
                default:
                begin
                    phase_next = lz4bd_pkg::PH_TOKEN;
                end
            endcase
        end

        // end of block: clear counters, drop the rest after an unmarked error
        if (fin) begin
            res_valid = 1'b1;
            prod_next = '0;
            endp_next = 1'b0;
            lit_next  = '0;
            mat_next  = '0;
            if (fin_st != lz4bd_pkg::ST_OK && !fin_last)
                phase_next = lz4bd_pkg::PH_DROP;
            else
                phase_next = lz4bd_pkg::PH_TOKEN;
        end
    end

    // Advance parser state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= lz4bd_pkg::PH_TOKEN;
            lit_reg   <= '0;
            mat_reg   <= '0;
            nib_reg   <= '0;
            dist_reg  <= '0;
            prod_reg  <= '0;
            endp_reg  <= 1'b0;
        end else if (in_acc) begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            mat_reg   <= mat_next;
            nib_reg   <= nib_next;
            dist_reg  <= dist_next;
            prod_reg  <= prod_next;
            endp_reg  <= endp_next;
        end
    end

    // Window addresses and the byte leaving the middle stage
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [7:0]        s1_byte;
    logic              wr_en;

    assign rd_addr = prod_reg[ADDR_W-1:0] - ADDR_W'(dist_reg);
    assign rd_en   = in_acc && (action == lz4bd_pkg::ACT_COPY)
                     && (phase_reg == lz4bd_pkg::PH_COPY);
    assign wr_en   = s1_valid_reg && s1_adv && s1_reg.has_byte;

    always_comb
    begin
        if (!s1_reg.has_byte)
            s1_byte = '0;
        else if (!s1_reg.is_copy)
            s1_byte = s1_reg.lit_byte;
        else if (s1_fwd_reg)
            s1_byte = s1_fwd_byte_reg;
        else
            s1_byte = mem_q_reg;
    end

    // History window: write the leaving byte, read for the entering copy tick
    always_ff @(posedge clk)
    begin
        if (wr_en)
            window_mem[s1_waddr_reg] <= s1_byte;
        if (rd_en)
            mem_q_reg <= window_mem[rd_addr];
    end

    // Middle stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= res_valid;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Middle stage payload; forward the byte written in the same cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && res_valid) begin
            s1_reg.is_copy   <= action;
            s1_reg.has_byte  <= res_emit;
            s1_reg.block_end <= fin;
            s1_reg.status    <= fin_st;
            s1_reg.length    <= res_emit ? prod_inc : prod_reg;
            s1_reg.lit_byte  <= in_byte;
            s1_waddr_reg     <= prod_reg[ADDR_W-1:0];
            s1_fwd_reg       <= wr_en && (s1_waddr_reg == rd_addr);
            s1_fwd_byte_reg  <= s1_byte;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg) begin
            s2_reg      <= s1_reg;
            s2_byte_reg <= s1_byte;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_byte   = s2_byte_reg;
    assign has_byte   = s2_reg.has_byte;
    assign block_end  = s2_reg.block_end;
    assign status     = s2_reg.status;
    assign out_length = s2_reg.length;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for lz4_block_decoder_top: directed LZ4 blocks, error endings,
// a long output stall and random well-formed and broken blocks, checked by a local decoder.
// Depends on lz4bd_pkg and lz4_block_decoder_top.
`timescale 1ns / 1ps

module testbench;

    localparam int LEN_W = lz4bd_pkg::LEN_W;
    localparam int CNT_W = lz4bd_pkg::CNT_W;
    localparam logic [2:0] CAP_ADDR = {lz4bd_pkg::REG_OUT_CAPACITY, 2'b00};

    // Shapes of random blocks
    typedef enum int {
        BLK_CLEAN,
        BLK_CUT,
        BLK_ZERO_OFF,
        BLK_FAR,
        BLK_PUSH_COPY,
        BLK_NOISE
    } blk_kind_t;

    // One decoded result as the block should report it
    typedef struct packed {
        logic [7:0]       obyte;
        logic             has;
        logic             fin;
        logic [3:0]       st;
        logic [CNT_W-1:0] len;
    } dec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = lz4bd_pkg::ACT_PUSH;
    logic [7:0]  in_byte = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        block_end;
    logic [3:0]  status;
    logic [30:0] out_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Local decoder state
    lz4bd_pkg::phase_t dec_ph = lz4bd_pkg::PH_TOKEN;
    logic [LEN_W-1:0]  lit_left = '0;
    logic [LEN_W-1:0]  mat_left = '0;
    logic [3:0]        mat_nib = 4'd0;
    logic [15:0]       mat_dist = 16'd0;
    logic [CNT_W-1:0]  produced = '0;
    logic              end_pend = 1'b0;
    logic [CNT_W-1:0]  cap_reg = lz4bd_pkg::CAP_RESET;
    logic [7:0]        hist [0:65535];

    dec_result_t decoded_q[$];
    dec_result_t want;
    bit          blk_done = 1'b0;
    int          useful_items = 0;
    int          err_count = 0;
    int          push_n = 0;
    int          cut_at = -1;
    int          rx_gap = 0;
    int          hold_left = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    lz4_block_decoder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .in_byte    (in_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .block_end  (block_end),
        .status     (status),
        .out_length (out_length),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up long after the slowest correct run
    initial
    begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- decoder

    function automatic logic [LEN_W-1:0] sat_add32(logic [LEN_W-1:0] a, logic [7:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + b;
        return s[LEN_W] ? lz4bd_pkg::LEN_MAX : s[LEN_W-1:0];
    endfunction

    function automatic void add_result(logic [7:0] v, logic has, logic fin, logic [3:0] st);
        decoded_q.push_back('{obyte: v, has: has, fin: fin, st: st, len: produced});
    endfunction

    // Close the block: report, clear the counters, drop the rest after an error
    function automatic void end_block(logic [7:0] v, logic has, logic [3:0] st, logic lst);
        add_result(v, has, 1'b1, st);
        produced = '0;
        end_pend = 1'b0;
        lit_left = '0;
        mat_left = '0;
        dec_ph   = (st != lz4bd_pkg::ST_OK && !lst) ? lz4bd_pkg::PH_DROP
                                                     : lz4bd_pkg::PH_TOKEN;
        blk_done = 1'b1;
    endfunction

    function automatic void store_byte(logic [7:0] v);
        hist[produced[15:0]] = v;
        produced = produced + 1'b1;
    endfunction

    function automatic void lit_len_done(logic lst);
        if ({2'b00, produced} + {1'b0, lit_left} > {2'b00, cap_reg})
            end_block(8'h00, 1'b0, lz4bd_pkg::ST_LIT_OVF, lst);
        else if (lit_left == 0)
        begin
            if (lst)
                end_block(8'h00, 1'b0, lz4bd_pkg::ST_OK, 1'b1);
            else
                dec_ph = lz4bd_pkg::PH_OFF0;
        end
        else if (lst)
            end_block(8'h00, 1'b0, lz4bd_pkg::ST_LITS_CUT, 1'b1);
        else
            dec_ph = lz4bd_pkg::PH_LIT;
    endfunction

    function automatic void match_len_done(logic lst);
        if (mat_dist > produced)
            end_block(8'h00, 1'b0, lz4bd_pkg::ST_OFF_FAR, lst);
        else if ({2'b00, produced} + {1'b0, mat_left} > {2'b00, cap_reg})
            end_block(8'h00, 1'b0, lz4bd_pkg::ST_MATCH_OVF, lst);
        else
        begin
            end_pend = lst;
            dec_ph   = lz4bd_pkg::PH_COPY;
        end
    endfunction

    // Decode one accepted item; returns 0 when the block ignores it
    function automatic bit decode_item(logic act, logic [7:0] b, logic lst);
        logic [7:0] v;
        if (act == lz4bd_pkg::ACT_COPY)
        begin
            if (dec_ph != lz4bd_pkg::PH_COPY)
                return 1'b0;
            v = hist[produced[15:0] - mat_dist];
            store_byte(v);
            mat_left = mat_left - 1'b1;
            if (mat_left == 0)
            begin
                if (end_pend)
                begin
                    end_block(v, 1'b1, lz4bd_pkg::ST_OK, 1'b1);
                    return 1'b1;
                end
                dec_ph = lz4bd_pkg::PH_TOKEN;
            end
            add_result(v, 1'b1, 1'b0, lz4bd_pkg::ST_OK);
            return 1'b1;
        end
        case (dec_ph)
            lz4bd_pkg::PH_TOKEN:
            begin
                mat_nib  = b[3:0];
                lit_left = {28'd0, b[7:4]};
                if (b[7:4] == lz4bd_pkg::NIBBLE_EXT)
                begin
                    if (lst)
                        end_block(8'h00, 1'b0, lz4bd_pkg::ST_LITLEN_CUT, 1'b1);
                    else
                        dec_ph = lz4bd_pkg::PH_LITEXT;
                end
                else
                    lit_len_done(lst);
            end
            lz4bd_pkg::PH_LITEXT:
            begin
                lit_left = sat_add32(lit_left, b);
                if (b == lz4bd_pkg::BYTE_EXT)
                begin
                    if (lst)
                        end_block(8'h00, 1'b0, lz4bd_pkg::ST_LITLEN_CUT, 1'b1);
                end
                else
                    lit_len_done(lst);
            end
            lz4bd_pkg::PH_LIT:
            begin
                store_byte(b);
                lit_left = lit_left - 1'b1;
                if (lit_left == 0)
                begin
                    if (lst)
                        end_block(b, 1'b1, lz4bd_pkg::ST_OK, 1'b1);
                    else
                    begin
                        dec_ph = lz4bd_pkg::PH_OFF0;
                        add_result(b, 1'b1, 1'b0, lz4bd_pkg::ST_OK);
                    end
                end
                else if (lst)
                    end_block(b, 1'b1, lz4bd_pkg::ST_LITS_CUT, 1'b1);
                else
                    add_result(b, 1'b1, 1'b0, lz4bd_pkg::ST_OK);
            end
            lz4bd_pkg::PH_OFF0:
            begin
                mat_dist = {8'd0, b};
                if (lst)
                    end_block(8'h00, 1'b0, lz4bd_pkg::ST_OFFSET_CUT, 1'b1);
                else
                    dec_ph = lz4bd_pkg::PH_OFF1;
            end
            lz4bd_pkg::PH_OFF1:
            begin
                mat_dist = {b, mat_dist[7:0]};
                if (mat_dist == 0)
                    end_block(8'h00, 1'b0, lz4bd_pkg::ST_ZERO_OFF, lst);
                else
                begin
                    mat_left = lz4bd_pkg::MATCH_MIN + mat_nib;
                    if (mat_nib == lz4bd_pkg::NIBBLE_EXT)
                    begin
                        if (lst)
                            end_block(8'h00, 1'b0, lz4bd_pkg::ST_MLEN_CUT, 1'b1);
                        else
                            dec_ph = lz4bd_pkg::PH_MEXT;
                    end
                    else
                        match_len_done(lst);
                end
            end
            lz4bd_pkg::PH_MEXT:
            begin
                mat_left = sat_add32(mat_left, b);
                if (b == lz4bd_pkg::BYTE_EXT)
                begin
                    if (lst)
                        end_block(8'h00, 1'b0, lz4bd_pkg::ST_MLEN_CUT, 1'b1);
                end
                else
                    match_len_done(lst);
            end
            lz4bd_pkg::PH_COPY:
                end_block(8'h00, 1'b0, lz4bd_pkg::ST_PUSH_COPY, lst);
            default:
            begin
                if (lst)
                    dec_ph = lz4bd_pkg::PH_TOKEN;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- channels

    function automatic int draw_gap(bit on);
        if (!on)
            return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    // Count down the long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receive results, compare with the oldest decoded result, then stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"unexpected result at %0t: byte %02h has %0d end %0d ",
                                  "st %0d len %0d"},
                                 $time, out_byte, has_byte, block_end, status, out_length);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.obyte || has_byte !== want.has ||
                        block_end !== want.fin || status !== want.st ||
                        out_length !== want.len)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch at %0t: expected byte %02h has %0d end %0d st %0d ",
                                      "len %0d, got byte %02h has %0d end %0d st %0d len %0d"},
                                     $time, want.obyte, want.has, want.fin, want.st, want.len,
                                     out_byte, has_byte, block_end, status, out_length);
                    end
                end
                rx_gap = draw_gap(rx_idle);
            end
            if (hold_left != 0)
                out_ready <= 1'b0;
            else if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap = rx_gap - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic act, input logic [7:0] b, input logic lst);
        int gap;
        gap = draw_gap(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        in_byte  <= b;
        last     <= lst;
        do @(posedge clk); while (!in_ready);
        if (decode_item(act, b, lst))
            useful_items++;
    endtask

    task automatic write_capacity(input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cap_reg = data[CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, wait for every result, then let trailing items settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- block builder

    // Push a compressed byte unless the block is already over; force an early cut
    task automatic push(input logic [7:0] b, input logic lst);
        if (blk_done)
            return;
        if (push_n == cut_at)
            lst = 1'b1;
        push_n++;
        send_item(lz4bd_pkg::ACT_PUSH, b, lst);
    endtask

    task automatic emit_ext(input int rem, input logic lst);
        while (rem >= 255)
        begin
            push(lz4bd_pkg::BYTE_EXT, 1'b0);
            rem -= 255;
        end
        push(8'(rem), lst);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 14);
        if (r < 18)
            return $urandom_range(15, 40);
        if (r == 18)
            return $urandom_range(14, 16);
        return $urandom_range(267, 273);
    endfunction

    // Bring the decoder back to a token boundary, draining any drop or copy
    task automatic close_block();
        if (dec_ph == lz4bd_pkg::PH_DROP)
            repeat ($urandom_range(0, 3))
                send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0);
        while (dec_ph != lz4bd_pkg::PH_TOKEN)
        begin
            if (dec_ph == lz4bd_pkg::PH_COPY)
                send_item(lz4bd_pkg::ACT_COPY, 8'($urandom), 1'($urandom_range(0, 1)));
            else
                send_item(lz4bd_pkg::ACT_PUSH, 8'($urandom), 1'b1);
        end
    endtask

    task automatic gen_block();
        blk_kind_t   kind;
        int          nseq, lits, mlen;
        int unsigned pc, offs;
        logic [3:0]  lnib, mnib;
        bit          fin, tail;
        blk_done = 1'b0;
        push_n   = 0;
        cut_at   = -1;
        kind     = BLK_CLEAN;
        if ($urandom_range(0, 9) < 3)
            kind = blk_kind_t'($urandom_range(BLK_CUT, BLK_NOISE));
        if (kind == BLK_CUT)
            cut_at = $urandom_range(0, 10);
        if (kind == BLK_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 3) == 0);
        end
        else
        begin
            nseq = $urandom_range(1, 4);
            for (int s = 0; s < nseq && !blk_done; s++)
            begin
                fin  = (s == nseq - 1);
                tail = fin && ($urandom_range(0, 1) == 1);
                lits = pick_len();
                mlen = pick_len() + 4;
                if (!tail && produced == 0 && lits == 0)
                    lits = 1;
                lnib = (lits >= 15) ? lz4bd_pkg::NIBBLE_EXT : 4'(lits);
                mnib = (mlen - 4 >= 15) ? lz4bd_pkg::NIBBLE_EXT : 4'(mlen - 4);
                push({lnib, mnib}, tail && lits == 0);
                if (lits >= 15)
                    emit_ext(lits - 15, 1'b0);
                for (int i = 0; i < lits; i++)
                    push(8'($urandom), tail && i == lits - 1);
                if (!tail)
                begin
                    // pick a distance back into this block's output, or a zero or too-far one for those block kinds
                    pc = produced;
                    if (pc == 0)
                        offs = 1;
                    else
                        offs = $urandom_range(1, (pc > 65535) ? 65535 : pc);
                    if (kind == BLK_ZERO_OFF)
                        offs = 0;
                    if (kind == BLK_FAR)
                        offs = (pc + 40 > 65535) ? 65535 : pc + $urandom_range(1, 40);
                    push(offs[7:0], 1'b0);
                    push(offs[15:8], fin && mnib != lz4bd_pkg::NIBBLE_EXT);
                    if (mnib == lz4bd_pkg::NIBBLE_EXT)
                        emit_ext(mlen - 19, fin);
                    // copy out the match, maybe breaking in with a push
                    while (dec_ph == lz4bd_pkg::PH_COPY)
                    begin
                        if (kind == BLK_PUSH_COPY && $urandom_range(0, 3) == 0)
                            push(8'($urandom), 1'($urandom_range(0, 1)));
                        else
                            send_item(lz4bd_pkg::ACT_COPY, 8'($urandom),
                                      1'($urandom_range(0, 1)));
                    end
                    if ($urandom_range(0, 7) == 0)
                        send_item(lz4bd_pkg::ACT_COPY, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end
        close_block();
    endtask

    // ---------------------------------------------------------------- tests

    // Stray tick, a literal-only block and an overlapping match that ends the block
    task automatic test_basic_blocks();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(lz4bd_pkg::ACT_COPY, 8'hFF, 1'b1);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h20, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'hFF, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h10, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'hA5, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
        repeat (4)
            send_item(lz4bd_pkg::ACT_COPY, 8'h00, 1'b0);
    endtask

    // Push during copy with the drop that follows, literals cut, zero offset
    task automatic test_error_ends();
        send_item(lz4bd_pkg::ACT_PUSH, 8'h10, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h3C, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h01, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
        send_item(lz4bd_pkg::ACT_COPY, 8'h00, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h77, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'hFF, 1'b1);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h30, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'hFF, 1'b1);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'h00, 1'b1);
    endtask

    // Hold the receiver off while a 40-literal block streams in without gaps
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_left <= 400;
        send_item(lz4bd_pkg::ACT_PUSH, 8'hF0, 1'b0);
        send_item(lz4bd_pkg::ACT_PUSH, 8'd25, 1'b0);
        for (int i = 0; i < 40; i++)
            send_item(lz4bd_pkg::ACT_PUSH, 8'($urandom), i == 39);
    endtask

    task automatic test_random(input logic [31:0] cap_word, input int n_items);
        int stop_at;
        wait_drained();
        write_capacity(cap_word);
        stop_at = useful_items + n_items;
        while (useful_items < stop_at)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            gen_block();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_blocks();
        test_error_ends();
        test_backpressure();
        test_random(32'h0001_0000, 1100);
        test_random(32'($urandom_range(8, 60)), 350);
        test_random(32'h0000_0000, 120);
        test_random(32'hFFFF_FFFF, 380);
        wait_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0 && decoded_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
